### hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: bus item formats,
// operation and result codes, and the pending result-job record.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  // Register file
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic RegPrgSize = 1'b0;
  localparam logic RegChrSize = 1'b1;
  localparam logic [7:0] PrgSizeRst = 8'd16;
  localparam logic [7:0] ChrSizeRst = 8'd0;
  localparam logic [7:0] ChrLargeLimit = 8'd32;

  // IRQ counter
  localparam logic [15:0] TickStep = 16'd114;

  // Mode field values (bits 5:4 of the mode register)
  localparam logic [1:0] ModeOff = 2'b00;
  localparam logic [1:0] ModeOne = 2'b11;
  localparam logic [7:0] ModeInit = 8'h30;

  // Decoded bus addresses
  localparam logic [15:0] AdrExpLo = 16'h5101;
  localparam logic [15:0] AdrExpHi = 16'h5103;
  localparam logic [7:0] AdrExpPage = 8'h51;
  localparam logic [15:0] AdrBlock0 = 16'h8000;
  localparam logic [15:0] AdrBlock1 = 16'hB000;
  localparam logic [15:0] AdrBlock2 = 16'hB0FF;
  localparam logic [15:0] AdrBlock3 = 16'hB1FF;
  localparam logic [15:0] AdrMode = 16'h8100;
  localparam logic [15:0] AdrIrqLo = 16'h8200;
  localparam logic [15:0] AdrIrqHi = 16'h8201;
  localparam logic [15:0] AdrPrgLo = 16'h8300;
  localparam logic [15:0] AdrPrgHi = 16'h8302;
  localparam logic [15:0] AdrChrLo = 16'h8310;
  localparam logic [15:0] AdrChrHi = 16'h8317;
  localparam logic [15:0] AdrPrgPair = 16'h8318;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpTick  = 2'd2,
    OpInit  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KindPrg    = 3'd0,
    KindChr    = 3'd1,
    KindMirror = 3'd2,
    KindIrq    = 3'd3,
    KindRead   = 3'd4
  } kind_e;

  // Result job held while its words go out
  typedef enum logic [2:0] {
    JobPrg,     // PRG pairs (a, h); beyond word 3 identity CHR words
    JobPrgOne,  // single PRG window
    JobChrOne,  // single 1KB CHR slot
    JobChrTwo,  // 2KB CHR pair
    JobMirror,
    JobIrq,
    JobRead
  } job_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] address;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot;
    logic [10:0] bank;
    logic [1:0]  mirror_mode;
    logic [7:0]  read_data;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_e       jtype;
    logic [3:0] last_idx;
    logic [2:0] slot;
    logic [9:0] bank_a;
    logic [9:0] bank_h;
    logic [7:0] data;
  } job_t;

endpackage

`default_nettype wire

### hw/rtl/cartridge_bank_mapper_with_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// Bank-switching mapper with expansion byte and scanline IRQ countdown.
// ----------------------------------------------------------------------------
// An accepted item updates the mapper state at once and loads a result job
// into the output register; the job emits one result word per cycle while
// out_ready_i is high. Items with no result or one result sustain one item
// per cycle when not stalled. An item with several results holds the output
// register until its last word leaves (block write 4, PRG pair and CHR pair
// 2, init 4 or 12 results); the next item is taken in that cycle. The config
// port (APB, no wait states) may be written only while the block is idle.
`default_nettype none

module cartridge_bank_mapper_with_irq (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  cbm_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output cbm_pkg::out_item_t           out_data_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [cbm_pkg::AddrW-1:0]    paddr,
  input  wire  [cbm_pkg::DataW-1:0]    pwdata,
  output logic [cbm_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  // Configuration registers
  logic [7:0] prg_size_q, chr_size_q;

  // Mapper state
  logic [7:0]  block_q, block_d;
  logic [7:0]  mode_q, mode_d;
  logic [7:0]  exp_q, exp_d;
  logic [9:0]  chr_off_q, chr_off_d;
  logic [15:0] irq_cnt_q, irq_cnt_d;
  logic        irq_en_q, irq_en_d;

  // Output job
  logic          busy_q, busy_d;
  logic [3:0]    idx_q, idx_d;
  cbm_pkg::job_t job_q, job_d;
  logic          new_job;

  logic in_fire, done, cfg_wr;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_size_q <= cbm_pkg::PrgSizeRst;
      chr_size_q <= cbm_pkg::ChrSizeRst;
    end else if (cfg_wr) begin
      if (paddr[2] == cbm_pkg::RegPrgSize) begin
        prg_size_q <= pwdata[7:0];
      end else begin
        chr_size_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == cbm_pkg::RegPrgSize) begin
      prdata = {24'd0, prg_size_q};
    end else begin
      prdata = {24'd0, chr_size_q};
    end
  end

  // Handshake: take a new item when the job register is free or drains now
  assign done        = busy_q & out_ready_i & (idx_q == job_q.last_idx);
  assign in_ready_o  = ~busy_q | done;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = busy_q;

  // Decode the item: next state and result job
  always_comb begin
    logic [15:0] adr;
    logic [7:0]  v;
    logic [9:0]  chr_b;
    logic [2:0]  cidx;

    adr = in_data_i.address;
    v   = in_data_i.value;
    chr_b = chr_off_q ^ {2'b00, v};
    cidx  = adr[2:0];

    block_d   = block_q;
    mode_d    = mode_q;
    exp_d     = exp_q;
    chr_off_d = chr_off_q;
    irq_cnt_d = irq_cnt_q;
    irq_en_d  = irq_en_q;

    new_job        = 1'b0;
    job_d.jtype    = cbm_pkg::JobPrg;
    job_d.last_idx = 4'd0;
    job_d.slot     = 3'd0;
    job_d.bank_a   = 10'd0;
    job_d.bank_h   = 10'd0;
    job_d.data     = 8'd0;

    case (in_data_i.operation)
      cbm_pkg::OpWrite: begin
        if (adr >= cbm_pkg::AdrExpLo && adr <= cbm_pkg::AdrExpHi) begin
          exp_d = v;
        end else if (adr == cbm_pkg::AdrBlock0 || adr == cbm_pkg::AdrBlock1 ||
                     adr == cbm_pkg::AdrBlock2 || adr == cbm_pkg::AdrBlock3) begin
          block_d        = v;
          chr_off_d      = {v[5:4], 8'd0};
          new_job        = 1'b1;
          job_d.jtype    = cbm_pkg::JobPrg;
          job_d.last_idx = 4'd3;
          job_d.bank_a   = {2'b00, v};
          job_d.bank_h   = {4'd0, v[5:4], 4'hF};
        end else if (adr == cbm_pkg::AdrMode) begin
          if (chr_size_q <= cbm_pkg::ChrLargeLimit) begin
            mode_d = v;
          end
          new_job     = 1'b1;
          job_d.jtype = cbm_pkg::JobMirror;
          job_d.data  = v;
        end else if (adr == cbm_pkg::AdrIrqLo) begin
          irq_cnt_d = {irq_cnt_q[15:8], v};
        end else if (adr == cbm_pkg::AdrIrqHi) begin
          irq_cnt_d = {v, irq_cnt_q[7:0]};
          irq_en_d  = (v != 8'd0);
        end else if (adr >= cbm_pkg::AdrPrgLo && adr <= cbm_pkg::AdrPrgHi) begin
          new_job      = 1'b1;
          job_d.jtype  = cbm_pkg::JobPrgOne;
          job_d.slot   = {1'b0, adr[1:0]};
          job_d.bank_a = {2'b00, v};
        end else if (adr >= cbm_pkg::AdrChrLo && adr <= cbm_pkg::AdrChrHi) begin
          if (mode_q[5:4] == cbm_pkg::ModeOne) begin
            new_job      = 1'b1;
            job_d.jtype  = cbm_pkg::JobChrOne;
            job_d.slot   = cidx;
            job_d.bank_a = chr_b;
          end else if (mode_q[5:4] != cbm_pkg::ModeOff) begin
            // upper four addresses fold onto the pairs at slots 4 and 6
            new_job        = 1'b1;
            job_d.jtype    = cbm_pkg::JobChrTwo;
            job_d.last_idx = 4'd1;
            job_d.slot     = cidx[2] ? {1'b1, cidx[0], 1'b0} : {cidx[1:0], 1'b0};
            job_d.bank_a   = chr_b;
          end
        end else if (adr == cbm_pkg::AdrPrgPair) begin
          new_job        = 1'b1;
          job_d.jtype    = cbm_pkg::JobPrg;
          job_d.last_idx = 4'd1;
          job_d.bank_a   = {2'b00, (block_q & 8'h30) | v};
        end
      end
      cbm_pkg::OpRead: begin
        if (adr[15:8] == cbm_pkg::AdrExpPage) begin
          new_job     = 1'b1;
          job_d.jtype = cbm_pkg::JobRead;
          job_d.data  = exp_q;
        end
      end
      cbm_pkg::OpTick: begin
        if (irq_en_q) begin
          if (irq_cnt_q <= cbm_pkg::TickStep) begin
            irq_en_d    = 1'b0;
            new_job     = 1'b1;
            job_d.jtype = cbm_pkg::JobIrq;
          end else begin
            irq_cnt_d = irq_cnt_q - cbm_pkg::TickStep;
          end
        end
      end
      cbm_pkg::OpInit: begin
        block_d   = 8'd0;
        mode_d    = 8'd0;
        exp_d     = 8'd0;
        chr_off_d = 10'd0;
        irq_cnt_d = 16'd0;
        irq_en_d  = 1'b0;
        new_job        = 1'b1;
        job_d.jtype    = cbm_pkg::JobPrg;
        job_d.last_idx = (chr_size_q != 8'd0) ? 4'd11 : 4'd3;
        job_d.bank_a   = 10'd0;
        if (prg_size_q >= 8'd16) begin
          mode_d       = cbm_pkg::ModeInit;
          job_d.bank_h = 10'd15;
        end else begin
          // last two 8KB banks wrap at 2048
          job_d.bank_h = {2'b00, prg_size_q} - 10'd1;
        end
      end
      default: begin
        new_job = 1'b0;
      end
    endcase
  end

  // Advance the job: next word, or load a fresh job
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (in_fire) begin
      busy_d = new_job;
      idx_d  = 4'd0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && out_ready_i) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q   <= 8'd0;
      mode_q    <= 8'd0;
      exp_q     <= 8'd0;
      chr_off_q <= 10'd0;
      irq_cnt_q <= 16'd0;
      irq_en_q  <= 1'b0;
      busy_q    <= 1'b0;
      idx_q     <= 4'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (in_fire) begin
        block_q   <= block_d;
        mode_q    <= mode_d;
        exp_q     <= exp_d;
        chr_off_q <= chr_off_d;
        irq_cnt_q <= irq_cnt_d;
        irq_en_q  <= irq_en_d;
      end
    end
  end

  // Hold the job payload
  always_ff @(posedge clk_i) begin
    if (in_fire && new_job) begin
      job_q <= job_d;
    end
  end

  // Form the current result word from the job and word index
  always_comb begin
    logic [3:0] cidx4;
    cidx4 = idx_q - 4'd4;

    out_data_o.kind        = cbm_pkg::KindPrg;
    out_data_o.slot        = 3'd0;
    out_data_o.bank        = 11'd0;
    out_data_o.mirror_mode = 2'd0;
    out_data_o.read_data   = 8'd0;
    out_data_o.last        = (idx_q == job_q.last_idx);

    case (job_q.jtype)
      cbm_pkg::JobPrg: begin
        if (idx_q < 4'd4) begin
          out_data_o.kind = cbm_pkg::KindPrg;
          out_data_o.slot = {1'b0, idx_q[1:0]};
          out_data_o.bank = {(idx_q[1] ? job_q.bank_h : job_q.bank_a), idx_q[0]};
        end else begin
          out_data_o.kind = cbm_pkg::KindChr;
          out_data_o.slot = cidx4[2:0];
          out_data_o.bank = {8'd0, cidx4[2:0]};
        end
      end
      cbm_pkg::JobPrgOne: begin
        out_data_o.kind = cbm_pkg::KindPrg;
        out_data_o.slot = job_q.slot;
        out_data_o.bank = {1'b0, job_q.bank_a};
      end
      cbm_pkg::JobChrOne: begin
        out_data_o.kind = cbm_pkg::KindChr;
        out_data_o.slot = job_q.slot;
        out_data_o.bank = {1'b0, job_q.bank_a};
      end
      cbm_pkg::JobChrTwo: begin
        out_data_o.kind = cbm_pkg::KindChr;
        out_data_o.slot = job_q.slot | {2'b00, idx_q[0]};
        out_data_o.bank = {job_q.bank_a, idx_q[0]};
      end
      cbm_pkg::JobMirror: begin
        out_data_o.kind        = cbm_pkg::KindMirror;
        out_data_o.mirror_mode = job_q.data[1:0];
      end
      cbm_pkg::JobIrq: begin
        out_data_o.kind = cbm_pkg::KindIrq;
      end
      cbm_pkg::JobRead: begin
        out_data_o.kind      = cbm_pkg::KindRead;
        out_data_o.read_data = job_q.data;
      end
      default: begin
        out_data_o.kind = cbm_pkg::KindPrg;
      end
    endcase
  end

endmodule

`default_nettype wire
